// ===== hdl/sem_pkg.sv =====
`timescale 1ns / 1ps

package sem_pkg;

  // field widths
  localparam int PIX_W   = 8;
  localparam int MAG_W   = 8;
  localparam int COL_W   = 10;
  localparam int ROW_W   = 12;
  localparam int IMG_W_W = 11;
  localparam int IMG_H_W = 13;
  localparam int CFG_W   = 13;

  // parameter defaults
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 4096;

  // register reset values and limits
  localparam logic [IMG_W_W-1:0] RST_IMAGE_WIDTH  = 11'd640;
  localparam logic [IMG_H_W-1:0] RST_IMAGE_HEIGHT = 13'd480;
  localparam int                 MIN_DIM          = 3;
  localparam logic [MAG_W-1:0]   MAG_MAX          = 8'd255;

  // square root: one result bit per step, MSB first
  localparam int ROOT_STEPS = MAG_W;
  localparam int ROOT_KW    = $clog2(ROOT_STEPS);

  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_e;

  // controller -> datapath
  typedef struct packed {
    logic clr_step;
    logic load;
    logic shift;
    logic grad;
    logic square;
    logic sum;
    logic root_step;
    logic out_load;
  } sem_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;
    logic emit;
    logic root_last;
    logic out_free;
  } sem_sts_t;

endpackage

// ===== hdl/sem_if.sv =====
`timescale 1ns / 1ps

interface sem_pix_if;
  logic                      valid;
  logic                      ready;
  logic [sem_pkg::PIX_W-1:0] pixel;
  logic                      start_of_frame;

  modport source (output valid, output pixel, output start_of_frame, input ready);
  modport sink   (input valid, input pixel, input start_of_frame, output ready);
endinterface

interface sem_res_if;
  logic                      valid;
  logic                      ready;
  logic [sem_pkg::MAG_W-1:0] magnitude;
  logic [sem_pkg::COL_W-1:0] center_col;
  logic [sem_pkg::ROW_W-1:0] center_row;
  logic                      frame_done;

  modport source (output valid, output magnitude, output center_col, output center_row,
                  output frame_done, input ready);
  modport sink   (input valid, input magnitude, input center_col, input center_row,
                  input frame_done, output ready);
endinterface

// ===== hdl/sem_ram.sv =====
`timescale 1ns / 1ps

module sem_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/sem_dp.sv =====
`timescale 1ns / 1ps

module sem_dp #(
  parameter int MAX_WIDTH  = sem_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = sem_pkg::DEF_MAX_HEIGHT
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // config
  input  logic                        cfg_we_i,
  input  sem_pkg::cfg_reg_e           cfg_idx_i,
  input  logic [sem_pkg::CFG_W-1:0]   cfg_data_i,
  // pixel payload
  input  logic [sem_pkg::PIX_W-1:0]   pixel_i,
  input  logic                        sof_i,
  // result
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [sem_pkg::MAG_W-1:0]   magnitude_o,
  output logic [sem_pkg::COL_W-1:0]   center_col_o,
  output logic [sem_pkg::ROW_W-1:0]   center_row_o,
  output logic                        frame_done_o,
  // control
  input  sem_pkg::sem_cmd_t           cmd_i,
  output sem_pkg::sem_sts_t           sts_o
);

  import sem_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int LW = 2 * PIX_W;   // one line-store entry: {row r-2, row r-1}

  // config registers
  logic [IMG_W_W-1:0] img_w_q;
  logic [IMG_H_W-1:0] img_h_q;
  logic [IMG_W_W-1:0] w_eff;
  logic [IMG_H_W-1:0] h_eff;

  // position
  logic [CW-1:0] col_q, col_d, c_eff;
  logic [RW-1:0] row_q, row_d, r_eff;
  logic          emit_d, last_d;

  // per-item latches
  logic [PIX_W-1:0] px_q;
  logic [CW-1:0]    c_q;
  logic [RW-1:0]    r_q;
  logic             emit_q, last_q;

  // line store and clearing pass
  logic [CW-1:0] clr_q;
  logic          ram_we;
  logic [CW-1:0] ram_waddr;
  logic [LW-1:0] ram_wdata;
  logic [LW-1:0] ram_rdata;

  // window and arithmetic
  logic [PIX_W-1:0]  win_q [9];
  logic [10:0]       gx_d, gy_d;
  logic signed [10:0] gx_q, gy_q;
  logic [20:0]       sqx_q, sqy_q;
  logic [21:0]       sum_q;
  logic              sat;
  logic [MAG_W-1:0]  res_q, trial;
  logic [2*MAG_W-1:0] trial_sq;
  logic [ROOT_KW-1:0] k_q;

  // result register
  logic              out_valid_q;
  logic [MAG_W-1:0]  mag_q;
  logic [COL_W-1:0]  ccol_q;
  logic [ROW_W-1:0]  crow_q;
  logic              done_q;
  logic [31:0]       ccol_full, crow_full;

  // clamp sizes to [3, MAX]
  always_comb begin
    priority if (img_w_q < IMG_W_W'(MIN_DIM)) begin
      w_eff = IMG_W_W'(MIN_DIM);
    end else if (32'(img_w_q) > 32'(MAX_WIDTH)) begin
      w_eff = IMG_W_W'(MAX_WIDTH);
    end else begin
      w_eff = img_w_q;
    end
    priority if (img_h_q < IMG_H_W'(MIN_DIM)) begin
      h_eff = IMG_H_W'(MIN_DIM);
    end else if (32'(img_h_q) > 32'(MAX_HEIGHT)) begin
      h_eff = IMG_H_W'(MAX_HEIGHT);
    end else begin
      h_eff = img_h_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w_q <= RST_IMAGE_WIDTH;
      img_h_q <= RST_IMAGE_HEIGHT;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_IMAGE_WIDTH:  img_w_q <= cfg_data_i[IMG_W_W-1:0];
        REG_IMAGE_HEIGHT: img_h_q <= cfg_data_i[IMG_H_W-1:0];
        default: ;
      endcase
    end
  end

  // position of the incoming item and the next one
  always_comb begin
    c_eff  = sof_i ? '0 : col_q;
    r_eff  = sof_i ? '0 : row_q;
    emit_d = (32'(c_eff) >= 32'd2) && (32'(r_eff) >= 32'd2) &&
             (32'(c_eff) < 32'(w_eff)) && (32'(r_eff) < 32'(h_eff));
    last_d = (32'(c_eff) + 32'd1 == 32'(w_eff)) && (32'(r_eff) + 32'd1 == 32'(h_eff));
    col_d  = c_eff + CW'(1);
    row_d  = r_eff;
    if (32'(c_eff) + 32'd1 >= 32'(w_eff)) begin
      col_d = '0;
      row_d = (32'(r_eff) + 32'd1 >= 32'(h_eff)) ? '0 : r_eff + RW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      clr_q <= '0;
    end else begin
      if (cmd_i.load) begin
        col_q <= col_d;
        row_q <= row_d;
      end
      if (cmd_i.clr_step) begin
        clr_q <= clr_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      px_q   <= pixel_i;
      c_q    <= c_eff;
      r_q    <= r_eff;
      emit_q <= emit_d;
      last_q <= last_d;
    end
  end

  // line store: read at accept, write back {old r-1, new pixel} next cycle
  always_comb begin
    ram_we    = cmd_i.clr_step | cmd_i.shift;
    ram_waddr = cmd_i.clr_step ? clr_q : c_q;
    ram_wdata = cmd_i.clr_step ? '0 : {ram_rdata[PIX_W-1:0], px_q};
  end

  sem_ram #(
    .WIDTH (LW),
    .DEPTH (MAX_WIDTH)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.load),
    .raddr_i (c_eff),
    .rdata_o (ram_rdata)
  );

  // 3x3 window, row-major, shifts left
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) begin
        win_q[i] <= '0;
      end
    end else if (cmd_i.shift) begin
      win_q[0] <= win_q[1];
      win_q[1] <= win_q[2];
      win_q[2] <= ram_rdata[LW-1:PIX_W];
      win_q[3] <= win_q[4];
      win_q[4] <= win_q[5];
      win_q[5] <= ram_rdata[PIX_W-1:0];
      win_q[6] <= win_q[7];
      win_q[7] <= win_q[8];
      win_q[8] <= px_q;
    end
  end

  // gradients, 11-bit two's complement (range +-1020)
  always_comb begin
    gx_d = 11'(win_q[0]) - 11'(win_q[2]) + (11'(win_q[3]) << 1) - (11'(win_q[5]) << 1)
         + 11'(win_q[6]) - 11'(win_q[8]);
    gy_d = 11'(win_q[0]) - 11'(win_q[6]) + (11'(win_q[1]) << 1) - (11'(win_q[7]) << 1)
         + 11'(win_q[2]) - 11'(win_q[8]);
  end

  // bit-serial floor sqrt of the low 16 bits; above that it saturates
  always_comb begin
    trial    = res_q | (MAG_W'(1) << k_q);
    trial_sq = (2*MAG_W)'(trial) * (2*MAG_W)'(trial);
    sat      = |sum_q[21:16];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.grad) begin
      gx_q <= $signed(gx_d);
      gy_q <= $signed(gy_d);
    end
    if (cmd_i.square) begin
      sqx_q <= 21'(gx_q * gx_q);
      sqy_q <= 21'(gy_q * gy_q);
    end
    if (cmd_i.sum) begin
      sum_q <= 22'(sqx_q) + 22'(sqy_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
      k_q   <= '0;
    end else if (cmd_i.sum) begin
      res_q <= '0;
      k_q   <= ROOT_KW'(ROOT_STEPS - 1);
    end else if (cmd_i.root_step) begin
      if (trial_sq <= sum_q[15:0]) begin
        res_q <= trial;
      end
      k_q <= k_q - ROOT_KW'(1);
    end
  end

  // result register
  assign ccol_full = 32'(c_q) - 32'd1;
  assign crow_full = 32'(r_q) - 32'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      mag_q  <= sat ? MAG_MAX : res_q;
      ccol_q <= ccol_full[COL_W-1:0];
      crow_q <= crow_full[ROW_W-1:0];
      done_q <= last_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign magnitude_o  = mag_q;
  assign center_col_o = ccol_q;
  assign center_row_o = crow_q;
  assign frame_done_o = done_q;

  assign sts_o.clr_last  = (clr_q == CW'(MAX_WIDTH - 1));
  assign sts_o.emit      = emit_q;
  assign sts_o.root_last = (k_q == '0);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  // a loaded result is presented next cycle
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |=> out_valid_q)
    else $error("result not presented after load");

endmodule

// ===== hdl/sem_ctrl.sv =====
`timescale 1ns / 1ps

module sem_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  sem_pkg::sem_sts_t sts_i,
  output sem_pkg::sem_cmd_t cmd_o
);

  import sem_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_WIN,
    S_GRAD,
    S_SQ,
    S_SUM,
    S_ROOT,
    S_OUT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: if (sts_i.clr_last) state_d = S_IDLE;
      S_IDLE:  if (in_valid_i) state_d = S_WIN;
      S_WIN:   state_d = sts_i.emit ? S_GRAD : S_IDLE;
      S_GRAD:  state_d = S_SQ;
      S_SQ:    state_d = S_SUM;
      S_SUM:   state_d = S_ROOT;
      S_ROOT:  if (sts_i.root_last) state_d = S_OUT;
      S_OUT:   if (sts_i.out_free) state_d = S_IDLE;
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    in_ready_o       = (state_q == S_IDLE);
    cmd_o.clr_step   = (state_q == S_CLEAR);
    cmd_o.load       = (state_q == S_IDLE) && in_valid_i;
    cmd_o.shift      = (state_q == S_WIN);
    cmd_o.grad       = (state_q == S_GRAD);
    cmd_o.square     = (state_q == S_SQ);
    cmd_o.sum        = (state_q == S_SUM);
    cmd_o.root_step  = (state_q == S_ROOT);
    cmd_o.out_load   = (state_q == S_OUT) && sts_i.out_free;
  end

  // every accepted item writes its line-store entry back next cycle
  a_load_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> cmd_o.shift)
    else $error("accepted item without write-back");

  // leaving the clearing pass only after the last entry
  a_clear_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && $past(state_q) == S_CLEAR) |-> $past(sts_i.clr_last))
    else $error("clearing pass cut short");

  // root iteration starts right after the sum is formed
  a_sum_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.sum |=> (state_q == S_ROOT && !in_ready_o))
    else $error("root iteration not started");

endmodule

// ===== hdl/sobel_edge_magnitude_3x3.sv =====
`timescale 1ns / 1ps

// 3x3 Sobel edge magnitude over a raster pixel stream.
// Input channel pix_i: one grayscale item per handshake (valid & ready), with
//   start_of_frame marking column 0, row 0. Position also wraps on its own
//   after the last pixel of a frame.
// Output channel res_o: one item per interior pixel (magnitude, centre
//   column/row, frame_done on the last one); border pixels give nothing.
// Config: cfg_we_i writes image_width (index 0) or image_height (index 1);
//   write only while the block is idle. Sizes are clamped to [3, MAX_*].
// Sequence: one item at a time, pix_i.ready low until it is done. An item that
//   gives a result passes line-store read, window shift, gradient, squares, sum,
//   8 square-root steps and output load; one that gives none, only the read and the shift.
// Reset: sizes go to 640x480, position to 0,0, and the line store is cleared
//   by a pass over all MAX_WIDTH entries during which pix_i.ready stays low.
// Stall: the output register holds its item until taken; the next pixel is
//   still accepted and worked on, and waits at the output stage only if the
//   earlier result has not been taken by then.
module sobel_edge_magnitude_3x3 #(
  parameter int MAX_WIDTH  = sem_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = sem_pkg::DEF_MAX_HEIGHT
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  sem_pkg::cfg_reg_e         cfg_idx_i,
  input  logic [sem_pkg::CFG_W-1:0] cfg_data_i,
  sem_pix_if.sink                   pix_i,
  sem_res_if.source                 res_o
);

  import sem_pkg::*;

  sem_cmd_t cmd;
  sem_sts_t sts;
  logic     in_ready;

  // controller: sequences one item at a time through the datapath
  sem_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (pix_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  assign pix_i.ready = in_ready;

  // datapath: counters, line store, window, gradient/magnitude, output register
  sem_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .pixel_i      (pix_i.pixel),
    .sof_i        (pix_i.start_of_frame),
    .out_valid_o  (res_o.valid),
    .out_ready_i  (res_o.ready),
    .magnitude_o  (res_o.magnitude),
    .center_col_o (res_o.center_col),
    .center_row_o (res_o.center_row),
    .frame_done_o (res_o.frame_done),
    .cmd_i        (cmd),
    .sts_o        (sts)
  );

endmodule

// ===== test/sobel_edge_magnitude_3x3_test.sv =====
`timescale 1ns / 1ps

module sobel_edge_magnitude_3x3_test;
  import sem_pkg::*;

  localparam int LINE_LEN  = DEF_MAX_WIDTH;
  localparam int GAP_MAX   = 18;    // longest wait either side draws per item
  localparam int HOLD_LEN  = 400;   // long result-side hold-off, in cycles
  localparam int SETTLE    = 30;    // margin for no-result items still in flight
  localparam int RAND_PIX  = 700;
  localparam int WIDE_W    = DEF_MAX_WIDTH / 2;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             sof;
  } pix_item_t;

  typedef struct packed {
    logic [MAG_W-1:0] magnitude;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             done;
  } mag_item_t;

  // pixel texture of one run
  typedef enum int unsigned {PAT_NOISE, PAT_BINARY, PAT_FLAT, PAT_GRAIN} pattern_e;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we;
  cfg_reg_e         cfg_idx;
  logic [CFG_W-1:0] cfg_data;

  sem_pix_if pix ();
  sem_res_if res ();

  sobel_edge_magnitude_3x3 DUT (
    .clk_i,
    .rst_ni,
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .pix_i      (pix),
    .res_o      (res)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of line buffers, window, position and sizes
  // ---------------------------------------------------------------------------
  logic [PIX_W-1:0]   line_mem [2*LINE_LEN];  // [0..LINE_LEN-1] row r-1, [LINE_LEN..] row r-2
  logic [PIX_W-1:0]   win [9];                // row-major, top row first
  int unsigned        next_col, next_row;
  logic [IMG_W_W-1:0] width_reg;
  logic [IMG_H_W-1:0] height_reg;

  pix_item_t   pixel_q [$];   // pixels waiting to be offered
  mag_item_t   grad_q [$];    // magnitudes expected, oldest first
  int unsigned pixels_queued;
  int unsigned mismatches;

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    if (v < MIN_DIM) return MIN_DIM;
    if (v > hi) return hi;
    return v;
  endfunction

  // Advance the window by one pixel; returns 1 when the pixel closes an
  // interior window, with the expected result in mag.
  function automatic bit sobel_step(input pix_item_t it, output mag_item_t mag);
    int unsigned w, h, col_at, row_at, ci;
    logic [PIX_W-1:0] top, mid;
    int gx, gy, sq, t, b;
    logic [MAG_W-1:0] root;
    bit hit;
    w = clamp_dim(width_reg, DEF_MAX_WIDTH);
    h = clamp_dim(height_reg, DEF_MAX_HEIGHT);
    if (it.sof) begin
      next_col = 0;
      next_row = 0;
    end
    col_at = next_col;
    row_at = next_row;
    ci     = col_at % LINE_LEN;
    mid    = line_mem[ci];
    top    = line_mem[LINE_LEN + ci];
    win[0] = win[1]; win[1] = win[2]; win[2] = top;
    win[3] = win[4]; win[4] = win[5]; win[5] = mid;
    win[6] = win[7]; win[7] = win[8]; win[8] = it.pixel;
    line_mem[LINE_LEN + ci] = mid;
    line_mem[ci]            = it.pixel;

    hit = col_at >= 2 && row_at >= 2 && col_at < w && row_at < h;
    mag = '0;
    if (hit) begin
      gx = (int'(win[0]) - int'(win[2])) + 2 * (int'(win[3]) - int'(win[5]))
         + (int'(win[6]) - int'(win[8]));
      gy = (int'(win[0]) - int'(win[6])) + 2 * (int'(win[1]) - int'(win[7]))
         + (int'(win[2]) - int'(win[8]));
      sq = gx * gx + gy * gy;
      // floor square root, one bit at a time from the top; saturate past 255
      root = '0;
      if (sq >= 65536) begin
        root = MAG_MAX;
      end else begin
        for (b = MAG_W - 1; b >= 0; b--) begin
          t = int'(root) | (1 << b);
          if (t * t <= sq) root = t[MAG_W-1:0];
        end
      end
      mag.magnitude = root;
      mag.col       = COL_W'(col_at - 1);
      mag.row       = ROW_W'(row_at - 1);
      mag.done      = col_at == w - 1 && row_at == h - 1;
    end

    // row wrap on the first column at or past the last one
    if (col_at + 1 >= w) begin
      next_col = 0;
      next_row = (row_at + 1 >= h) ? 0 : row_at + 1;
    end else begin
      next_col = col_at + 1;
    end
    return hit;
  endfunction

  // Per-item wait: when idling, half the items go at once, the rest wait 0..GAP_MAX; otherwise none waits.
  function automatic int unsigned draw_wait(bit idling);
    if (!idling || $urandom_range(0, 1) == 0) return 0;
    return $urandom_range(0, GAP_MAX);
  endfunction

  // ---------------------------------------------------------------------------
  // Pixel driver: offers queued items, predicts on every accepted one
  // ---------------------------------------------------------------------------
  bit          send_idle;
  int unsigned send_gap;
  pix_item_t   offered;

  always @(posedge clk_i) begin
    mag_item_t m;
    if (!rst_ni) begin
      pix.valid <= 1'b0;
    end else begin
      if (pix.valid && pix.ready) begin
        if (sobel_step(offered, m)) grad_q.push_back(m);
      end
      if (!pix.valid || pix.ready) begin
        if (send_gap != 0) begin
          send_gap--;
          pix.valid <= 1'b0;
        end else if (pixel_q.size() != 0) begin
          offered = pixel_q.pop_front();
          pix.valid          <= 1'b1;
          pix.pixel          <= offered.pixel;
          pix.start_of_frame <= offered.sof;
          send_gap = draw_wait(send_idle);
        end else begin
          pix.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Long hold-off of the result side, asked for by the stimulus process
  // ---------------------------------------------------------------------------
  int unsigned holds_asked, holds_given, hold_left;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (holds_given != holds_asked) begin
      hold_left   <= HOLD_LEN;
      holds_given <= holds_given + 1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: every taken item against the oldest expectation
  // ---------------------------------------------------------------------------
  bit          take_idle;
  int unsigned take_gap;

  always @(posedge clk_i) begin
    mag_item_t want, got;
    if (!rst_ni) begin
      res.ready <= 1'b0;
    end else begin
      if (res.valid && res.ready) begin
        got = '{magnitude: res.magnitude, col: res.center_col, row: res.center_row,
                done: res.frame_done};
        if (grad_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result mag %0d col %0d row %0d done %0b",
                     $time, got.magnitude, got.col, got.row, got.done);
        end else begin
          want = grad_q.pop_front();
          if (got.magnitude !== want.magnitude || got.col !== want.col ||
              got.row !== want.row || got.done !== want.done) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"%0t: mismatch exp mag %0d col %0d row %0d done %0b,",
                        " got mag %0d col %0d row %0d done %0b"},
                       $time, want.magnitude, want.col, want.row, want.done,
                       got.magnitude, got.col, got.row, got.done);
          end
        end
        take_gap = draw_wait(take_idle);
      end
      if (hold_left != 0) begin
        res.ready <= 1'b0;
      end else if (take_gap != 0) begin
        take_gap--;
        res.ready <= 1'b0;
      end else begin
        res.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void push_pixel(logic [PIX_W-1:0] px, logic sof);
    pixel_q.push_back('{pixel: px, sof: sof});
    pixels_queued++;
  endfunction

  function automatic logic [PIX_W-1:0] pick_pixel(pattern_e pat, logic [PIX_W-1:0] base);
    case (pat)
      PAT_NOISE:  return PIX_W'($urandom);
      PAT_BINARY: return ($urandom_range(0, 1) != 0) ? MAG_MAX : '0;
      PAT_FLAT:   return base;
      default:    return base + PIX_W'($urandom_range(0, 15));
    endcase
  endfunction

  // n pixels of one texture; optional frame start on the first, and a stray
  // start_of_frame with odds 1 in sof_odds (0: none)
  function automatic void push_run(int unsigned n, bit lead_sof, int unsigned sof_odds);
    pattern_e         pat;
    logic [PIX_W-1:0] base;
    pat  = pattern_e'($urandom_range(0, 3));
    base = PIX_W'($urandom);
    for (int unsigned i = 0; i < n; i++)
      push_pixel(pick_pixel(pat, base),
                 (i == 0 && lead_sof) || (sof_odds != 0 && $urandom_range(1, sof_odds) == 1));
  endfunction

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_W-1:0] data);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == REG_IMAGE_WIDTH) width_reg = data[IMG_W_W-1:0];
    else height_reg = data;
  endtask

  // Sender pause: everything offered and taken, then let no-result items finish.
  task automatic settle();
    do @(negedge clk_i); while (pixel_q.size() != 0 || pix.valid || grad_q.size() != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned start_count, phase, fw, fh, w, h;
    rst_ni   = 1'b0;
    cfg_we   = 1'b0;
    cfg_idx  = REG_IMAGE_WIDTH;
    cfg_data = '0;
    pix.valid          = 1'b0;
    pix.pixel          = '0;
    pix.start_of_frame = 1'b0;
    res.ready          = 1'b0;
    width_reg  = RST_IMAGE_WIDTH;
    height_reg = RST_IMAGE_HEIGHT;
    foreach (line_mem[i]) line_mem[i] = '0;
    foreach (win[i]) win[i] = '0;
    next_col = 0;
    next_row = 0;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    // the line-store clearing pass holds ready low
    do @(negedge clk_i); while (!pix.ready);

    // Directed: 3x3 frames. Width written with junk above bit 10, which is dropped.
    write_reg(REG_IMAGE_WIDTH, 13'h1803);
    write_reg(REG_IMAGE_HEIGHT, CFG_W'(MIN_DIM));
    send_idle = 1'b1;
    take_idle = 1'b1;
    @(negedge clk_i);
    // dark left column against full white right: magnitude saturates
    for (int i = 0; i < 9; i++) push_pixel((i % 3 == 2) ? MAG_MAX : 8'd0, i == 0);
    // next frame begins by position wrap alone; small corner bump
    for (int i = 0; i < 9; i++) push_pixel((i == 0) ? 8'd10 : 8'd0, 1'b0);
    // frame start mid-frame, line buffers keep the old rows
    for (int i = 0; i < 4; i++) push_pixel(MAG_MAX, 1'b0);
    for (int i = 0; i < 3; i++) push_pixel(PIX_W'($urandom), i == 0);
    settle();

    // Random: mostly whole small frames with random content, some cut short,
    // some relying on wrap, some noise with stray frame starts.
    start_count = pixels_queued;
    phase = 0;
    while (pixels_queued - start_count < RAND_PIX) begin
      phase++;
      if (phase % 4 == 3) begin
        // beyond the top of both ranges: clamps to the largest size
        write_reg(REG_IMAGE_WIDTH, 13'h07FF);
        write_reg(REG_IMAGE_HEIGHT, 13'h1FFF);
      end else if (phase == 1 || phase == 6 || $urandom_range(0, 3) != 0) begin
        w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
        h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 10);
        write_reg(REG_IMAGE_WIDTH, CFG_W'(w | ($urandom_range(0, 3) << IMG_W_W)));
        write_reg(REG_IMAGE_HEIGHT, CFG_W'(h));
      end
      send_idle = $urandom_range(0, 3) != 0;
      take_idle = $urandom_range(0, 3) != 0;
      fw = clamp_dim(width_reg, DEF_MAX_WIDTH);
      fh = clamp_dim(height_reg, DEF_MAX_HEIGHT);
      @(negedge clk_i);
      if (fw * fh > 200) begin
        push_run($urandom_range(1, 40), 1, 0);   // large size: only a short start
      end else begin
        repeat ($urandom_range(1, 3)) begin
          case ($urandom_range(0, 9))
            0:       push_run($urandom_range(1, 3 * fw), 1'b0, 8);
            1:       push_run($urandom_range(1, fw * fh - 1), 1'b1, 0);
            2:       push_run(fw * fh, 1'b0, 0);
            default: push_run(fw * fh, 1'b1, 0);
          endcase
        end
      end
      if (phase == 6) begin
        // result side stops taking while pixels keep coming: input must stall
        send_idle = 1'b0;
        repeat (3) push_run(fw * fh, 1'b1, 0);
        holds_asked++;
      end
      settle();
    end

    // Wide line: two full rows before any window closes, then a bit more.
    write_reg(REG_IMAGE_WIDTH, CFG_W'(WIDE_W));
    write_reg(REG_IMAGE_HEIGHT, CFG_W'(MIN_DIM));
    send_idle = 1'b0;
    take_idle = 1'b1;
    @(negedge clk_i);
    push_run(2 * WIDE_W + 40, 1'b1, 0);
    settle();

    // Tallest frame on the narrowest rows; only the top part is sent.
    write_reg(REG_IMAGE_WIDTH, CFG_W'(MIN_DIM));
    write_reg(REG_IMAGE_HEIGHT, CFG_W'(DEF_MAX_HEIGHT));
    send_idle = 1'b1;
    @(negedge clk_i);
    push_run(3 * 60, 1'b1, 0);
    settle();

    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Run limit: far beyond the slowest legal run of this sequence.
  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
